### hdl/fr_pkg.sv
// fr_pkg: shared constants and types for the fraction reducer.
// Used by fr_front, fr_queue, fr_back and fraction_reducer; no dependencies.
`default_nettype none

package fr_pkg;

   localparam int VALUE_WIDTH_DEFAULT = 32;
   localparam int QUEUE_DEPTH         = 2;

   // Classification carried beside the magnitudes through the queue
   typedef struct packed {
      logic invalid;
      logic num_neg;
      logic den_neg;
   } fr_flags_type;

   localparam int FLAGS_WIDTH = $bits(fr_flags_type);

   typedef enum logic [2:0] {
      FR_IDLE,
      FR_GCD,
      FR_DIV_NUM,
      FR_DIV_DEN,
      FR_DONE
   } fr_state_type;

   // Status from the queue to the front and back ends
   typedef struct packed {
      logic valid;
      logic full;
   } fr_queue_status_type;

endpackage

`default_nettype wire

### hdl/fraction_reducer.sv
// fraction_reducer: top level; reduces signed fractions to lowest terms.
// Instantiates fr_front, fr_queue and fr_back; uses fr_pkg.
//
//   channel | dir | handshake            | contents
//   req     | in  | req_tvalid/tready    | tdata: numerator, denominator
//   rsp     | out | rsp_tvalid/tready    | tdata: reduced num, reduced den;
//           |     |                      | tuser: invalid
//
// One fraction at a time in the back end: a dispatch state, a binary GCD of
// one step per cycle (data dependent), then two divisions on one shared
// divider, then the rsp register. Zero denominators skip straight to the result.
// The queue takes up to QUEUE_DEPTH req transfers while the back end is busy
// or rsp is stalled; req_tready drops when it is full.
// Synchronous reset empties the queue and the rsp register.
`default_nettype none

module fraction_reducer #(
   parameter int VALUE_WIDTH = fr_pkg::VALUE_WIDTH_DEFAULT
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     req_tvalid,
   output      logic                                     req_tready,
   // numerator, denominator, zero pad to bytes
   input  wire logic [8*((2*VALUE_WIDTH+7)/8)-1:0]      req_tdata,
   output      logic                                     rsp_tvalid,
   input  wire logic                                     rsp_tready,
   // reduced_numerator, reduced_denominator, zero pad to bytes
   output      logic [8*((2*VALUE_WIDTH+7)/8)-1:0]      rsp_tdata,
   // invalid
   output      logic                                     rsp_tuser
);
   import fr_pkg::*;

   localparam int TW = 8 * ((2 * VALUE_WIDTH + 7) / 8);
   localparam int QW = 2 * VALUE_WIDTH + FLAGS_WIDTH;

   fr_queue_status_type q_status;
   logic                q_push;
   logic                q_pop;
   logic [QW-1:0]       q_wdata;
   logic [QW-1:0]       q_rdata;

   fr_front #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .REQ_WIDTH   (TW)
   ) u_front (
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_status   (q_status),
      .q_push     (q_push),
      .q_wdata    (q_wdata)
   );

   fr_queue #(
      .DATA_WIDTH (QW),
      .DEPTH      (QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (q_push),
      .wdata  (q_wdata),
      .pop    (q_pop),
      .rdata  (q_rdata),
      .status (q_status)
   );

   fr_back #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .RSP_WIDTH   (TW)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .q_rdata    (q_rdata),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

### hdl/fr_front.sv
// fr_front: input side of the fraction reducer; takes req transfers,
// splits signs from magnitudes and flags a zero denominator. Uses fr_pkg.
`default_nettype none

module fr_front #(
   parameter int VALUE_WIDTH = fr_pkg::VALUE_WIDTH_DEFAULT,
   parameter int REQ_WIDTH   = 64
) (
   input  wire logic                                   reset,
   input  wire logic                                   req_tvalid,
   output      logic                                   req_tready,
   input  wire logic [REQ_WIDTH-1:0]                   req_tdata,
   input  wire fr_pkg::fr_queue_status_type            q_status,
   output      logic                                   q_push,
   output      logic [2*VALUE_WIDTH+fr_pkg::FLAGS_WIDTH-1:0] q_wdata
);
   import fr_pkg::*;

   localparam int W = VALUE_WIDTH;

   logic [W-1:0]  num;
   logic [W-1:0]  den;
   logic [W-1:0]  num_mag;
   logic [W-1:0]  den_mag;
   fr_flags_type  flags;

   assign num = req_tdata[W-1:0];
   assign den = req_tdata[2*W-1:W];

   always_comb begin
      flags.num_neg = num[W-1];
      flags.den_neg = den[W-1];
      flags.invalid = (den == '0);
      // most negative value maps to 2^(W-1), which still fits unsigned
      num_mag = num[W-1] ? ((~num) + {{(W-1){1'b0}}, 1'b1}) : num;
      den_mag = den[W-1] ? ((~den) + {{(W-1){1'b0}}, 1'b1}) : den;
   end

   assign req_tready = !q_status.full && !reset;
   assign q_push     = req_tvalid && req_tready;
   assign q_wdata    = {flags, num_mag, den_mag};

endmodule

`default_nettype wire

### hdl/fr_queue.sv
// fr_queue: short FIFO between the classifying front end and the back end.
// Register storage, one write and one read port. Uses fr_pkg.
`default_nettype none

module fr_queue #(
   parameter int DATA_WIDTH = 67,
   parameter int DEPTH      = fr_pkg::QUEUE_DEPTH
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         push,
   input  wire logic [DATA_WIDTH-1:0]        wdata,
   input  wire logic                         pop,
   output      logic [DATA_WIDTH-1:0]        rdata,
   output      fr_pkg::fr_queue_status_type  status
);
   import fr_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [DATA_WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]         count_ff, count_in;
   logic                  do_push, do_pop;

   assign status.valid = (count_ff != '0);
   assign status.full  = (count_ff == CW'(DEPTH));
   assign do_push      = push && !status.full;
   assign do_pop       = pop && status.valid;
   assign rdata        = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

`default_nettype wire

### hdl/fr_back.sv
// fr_back: execution side; binary GCD one step per cycle, then a shared
// restoring divider for numerator and denominator, then the rsp register.
// Zero denominators skip straight to the rsp register. Uses fr_pkg.
`default_nettype none

module fr_back #(
   parameter int VALUE_WIDTH = fr_pkg::VALUE_WIDTH_DEFAULT,
   parameter int RSP_WIDTH   = 64
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire fr_pkg::fr_queue_status_type            q_status,
   input  wire logic [2*VALUE_WIDTH+fr_pkg::FLAGS_WIDTH-1:0] q_rdata,
   output      logic                                   q_pop,
   output      logic                                   rsp_tvalid,
   input  wire logic                                   rsp_tready,
   output      logic [RSP_WIDTH-1:0]                   rsp_tdata,
   output      logic                                   rsp_tuser
);
   import fr_pkg::*;

   localparam int W  = VALUE_WIDTH;
   localparam int KW = $clog2(W);

   fr_state_type  state_ff, state_in;
   fr_flags_type  flags_ff, flags_in;
   logic [W-1:0]  num_mag_ff, num_mag_in;
   logic [W-1:0]  den_mag_ff, den_mag_in;
   logic [W-1:0]  a_ff, a_in;
   logic [W-1:0]  b_ff, b_in;
   logic [KW-1:0] k_ff, k_in;
   logic [W-1:0]  g_ff, g_in;
   logic [W-1:0]  quo_ff, quo_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [KW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  rnum_ff, rnum_in;
   logic          out_valid_ff, out_valid_in;
   logic [W-1:0]  out_num_ff, out_num_in;
   logic [W-1:0]  out_den_ff, out_den_in;
   logic          out_inv_ff, out_inv_in;

   fr_flags_type  q_flags;
   logic [W-1:0]  q_num_mag;
   logic [W-1:0]  q_den_mag;
   logic          gcd_done;
   logic          div_last;
   logic          out_load;
   logic [W:0]    trial;
   logic [W-1:0]  quo_step;
   logic [W-1:0]  rem_step;

   assign {q_flags, q_num_mag, q_den_mag} = q_rdata;

   assign gcd_done = (a_ff == '0);
   assign div_last = (cnt_ff == KW'(W - 1));

   // one restoring-division step
   always_comb begin
      trial = {rem_ff, quo_ff[W-1]} - {1'b0, g_ff};
      if (!trial[W]) begin
         rem_step = trial[W-1:0];
         quo_step = {quo_ff[W-2:0], 1'b1};
      end else begin
         rem_step = {rem_ff[W-2:0], quo_ff[W-1]};
         quo_step = {quo_ff[W-2:0], 1'b0};
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FR_IDLE: begin
            if (q_status.valid) begin
               state_in = q_flags.invalid ? FR_DONE : FR_GCD;
            end
         end
         FR_GCD: begin
            if (gcd_done) state_in = FR_DIV_NUM;
         end
         FR_DIV_NUM: begin
            if (div_last) state_in = FR_DIV_DEN;
         end
         FR_DIV_DEN: begin
            if (div_last) state_in = FR_DONE;
         end
         FR_DONE: begin
            if (out_load) state_in = FR_IDLE;
         end
         default: state_in = FR_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      q_pop    = 1'b0;
      out_load = 1'b0;
      case (state_ff)
         FR_IDLE: q_pop    = q_status.valid;
         FR_DONE: out_load = !out_valid_ff || rsp_tready;
         default: begin
            q_pop    = 1'b0;
            out_load = 1'b0;
         end
      endcase
   end

   // datapath
   always_comb begin
      flags_in   = flags_ff;
      num_mag_in = num_mag_ff;
      den_mag_in = den_mag_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      k_in       = k_ff;
      g_in       = g_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      cnt_in     = cnt_ff;
      rnum_in    = rnum_ff;
      out_num_in = out_num_ff;
      out_den_in = out_den_ff;
      out_inv_in = out_inv_ff;
      case (state_ff)
         FR_IDLE: begin
            flags_in   = q_flags;
            num_mag_in = q_num_mag;
            den_mag_in = q_den_mag;
            a_in       = q_num_mag;
            b_in       = q_den_mag;
            k_in       = '0;
            rnum_in    = '0;
            quo_in     = '0;
         end
         FR_GCD: begin
            if (gcd_done) begin
               // zero numerator lands here at once with g = |den|
               g_in   = b_ff << k_ff;
               quo_in = num_mag_ff;
               rem_in = '0;
               cnt_in = '0;
            end else if (!a_ff[0] && !b_ff[0]) begin
               a_in = a_ff >> 1;
               b_in = b_ff >> 1;
               k_in = k_ff + 1'b1;
            end else if (!a_ff[0]) begin
               a_in = a_ff >> 1;
            end else if (!b_ff[0]) begin
               b_in = b_ff >> 1;
            end else if (a_ff >= b_ff) begin
               a_in = a_ff - b_ff;
            end else begin
               b_in = b_ff - a_ff;
            end
         end
         FR_DIV_NUM: begin
            quo_in = quo_step;
            rem_in = rem_step;
            cnt_in = cnt_ff + 1'b1;
            if (div_last) begin
               rnum_in = quo_step;
               quo_in  = den_mag_ff;
               rem_in  = '0;
               cnt_in  = '0;
            end
         end
         FR_DIV_DEN: begin
            quo_in = quo_step;
            rem_in = rem_step;
            cnt_in = cnt_ff + 1'b1;
         end
         FR_DONE: begin
            if (out_load) begin
               out_inv_in = flags_ff.invalid;
               if (flags_ff.invalid) begin
                  out_num_in = '0;
                  out_den_in = '0;
               end else begin
                  out_num_in = flags_ff.num_neg ?
                               ((~rnum_ff) + {{(W-1){1'b0}}, 1'b1}) : rnum_ff;
                  out_den_in = flags_ff.den_neg ?
                               ((~quo_ff) + {{(W-1){1'b0}}, 1'b1}) : quo_ff;
               end
            end
         end
         default: begin
            flags_in = flags_ff;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FR_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      flags_ff   <= flags_in;
      num_mag_ff <= num_mag_in;
      den_mag_ff <= den_mag_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      k_ff       <= k_in;
      g_ff       <= g_in;
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      cnt_ff     <= cnt_in;
      rnum_ff    <= rnum_in;
      out_num_ff <= out_num_in;
      out_den_ff <= out_den_in;
      out_inv_ff <= out_inv_in;
   end

   always_comb begin
      rsp_tdata          = '0;
      rsp_tdata[W-1:0]   = out_num_ff;
      rsp_tdata[2*W-1:W] = out_den_ff;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_inv_ff;

endmodule

`default_nettype wire

### tb/sv/fraction_reducer_tb.sv
// fraction_reducer_tb: self-checking bench for fraction_reducer; a directed set of corner
// fractions, then random fractions under four idling patterns, checked in order of arrival.
// Depends on fr_pkg and the fraction_reducer RTL only.
`default_nettype none

module fraction_reducer_tb;

   localparam int W          = fr_pkg::VALUE_WIDTH_DEFAULT;
   localparam int DATA_W     = 8*((2*W+7)/8);
   localparam int PHASE_ITEMS = 220;
   localparam int TAIL_CYCLES = 400;
   localparam int CYCLE_LIMIT = 2000000;

   localparam logic [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};
   localparam logic [W-1:0] MOST_POS = {1'b0, {(W-1){1'b1}}};

   typedef logic [W-1:0] value_type;

   typedef struct {
      value_type num;
      value_type den;
      logic      invalid;
   } reduced_type;

   // Reduces each accepted fraction and matches rsp transfers against it in order
   class fraction_scoreboard;
      reduced_type pending_q[$];
      int          errors;

      function new();
         errors = 0;
      endfunction

      function void note_fraction(value_type n, value_type d);
         reduced_type e;
         value_type   n_mag;
         value_type   d_mag;
         value_type   x;
         value_type   y;
         value_type   r;
         if (d == '0) begin
            e.num     = '0;
            e.den     = '0;
            e.invalid = 1'b1;
         end else begin
            // magnitude of the most negative value is 2^(W-1), exact as unsigned
            n_mag = n[W-1] ? ~n + 1'b1 : n;
            d_mag = d[W-1] ? ~d + 1'b1 : d;
            x = n_mag;
            y = d_mag;
            while (y != '0) begin
               r = x % y;
               x = y;
               y = r;
            end
            e.num     = n[W-1] ? ~(n_mag / x) + 1'b1 : n_mag / x;
            e.den     = d[W-1] ? ~(d_mag / x) + 1'b1 : d_mag / x;
            e.invalid = 1'b0;
         end
         pending_q.push_back(e);
      endfunction

      function void check_result(logic [DATA_W-1:0] data, logic invalid);
         reduced_type e;
         value_type   got_num;
         value_type   got_den;
         if (pending_q.size() == 0) begin
            $error("rsp transfer with no fraction outstanding");
            errors++;
            return;
         end
         e       = pending_q.pop_front();
         got_num = data[W-1:0];
         got_den = data[2*W-1:W];
         if (got_num !== e.num) begin
            $error("reduced_numerator: expected %0d, got %0d",
                   $signed(e.num), $signed(got_num));
            errors++;
         end
         if (got_den !== e.den) begin
            $error("reduced_denominator: expected %0d, got %0d",
                   $signed(e.den), $signed(got_den));
            errors++;
         end
         if (invalid !== e.invalid) begin
            $error("invalid: expected %0b, got %0b", e.invalid, invalid);
            errors++;
         end
      endfunction

      function int outstanding();
         return pending_q.size();
      endfunction
   endclass

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_tvalid  = 1'b0;
   logic              req_tready;
   logic [DATA_W-1:0] req_tdata   = '0;    // numerator, denominator, zero pad
   logic              rsp_tvalid;
   logic              rsp_tready  = 1'b0;
   logic [DATA_W-1:0] rsp_tdata;           // reduced_numerator, reduced_denominator, zero pad
   logic              rsp_tuser;           // invalid

   fraction_scoreboard fractions = new();

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int cycles        = 0;

   fraction_reducer #(.VALUE_WIDTH(W)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("fraction_reducer test failed");
         $finish;
      end
   end

   // Result side: check on transfer, then pick the next ready level
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            fractions.check_result(rsp_tdata, rsp_tuser);
         rsp_tready <= ($urandom_range(99, 0) >= rsp_stall_pct);
      end
   end

   // Called in the step of a rising edge; returns in the step of the accepting edge
   task automatic send_fraction(input value_type n, input value_type d);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= DATA_W'({d, n});
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      fractions.note_fraction(n, d);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (fractions.outstanding() != 0)
         @(posedge clock);
   endtask

   function automatic value_type random_sign(value_type v);
      return $urandom_range(1, 0) ? ~v + 1'b1 : v;
   endfunction

   task automatic send_random_fraction();
      value_type n;
      value_type d;
      value_type g;
      int        pick;
      pick = $urandom_range(99, 0);
      if (pick < 35) begin
         // shared factor so the reduction is nontrivial
         g = $urandom_range(65535, 1);
         n = random_sign(g * value_type'($urandom_range(32767, 0)));
         d = random_sign(g * value_type'($urandom_range(32767, 1)));
      end else if (pick < 65) begin
         n = $urandom();
         d = $urandom();
      end else if (pick < 80) begin
         n = random_sign($urandom_range(24, 0));
         d = random_sign($urandom_range(24, 0));
      end else if (pick < 88) begin
         n = $urandom();
         d = '0;
      end else if (pick < 94) begin
         n = '0;
         d = $urandom();
      end else begin
         n = $urandom_range(1, 0) ? MOST_NEG : MOST_POS;
         d = random_sign(value_type'(1) << $urandom_range(W-1, 0));
      end
      send_fraction(n, d);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // corners: zero denominators, zero numerators, sign mixes, extremes
      send_fraction('0, '0);
      send_fraction(5, '0);
      send_fraction(MOST_NEG, '0);
      send_fraction(MOST_POS, '0);
      send_fraction('0, 5);
      send_fraction('0, -5);
      send_fraction('0, MOST_NEG);
      send_fraction(3, -6);
      send_fraction(-3, 6);
      send_fraction(-3, -6);
      send_fraction(12, 18);
      send_fraction(1, 1);
      send_fraction(-1, -1);
      send_fraction(MOST_POS, MOST_POS);
      send_fraction(MOST_NEG + 1'b1, MOST_POS);
      send_fraction(MOST_NEG, 3);
      send_fraction(MOST_NEG, MOST_NEG);
      send_fraction(MOST_NEG, 2);
      send_fraction(MOST_NEG, MOST_NEG >>> 1);
      send_fraction(MOST_POS, MOST_NEG);
      send_fraction(MOST_POS, MOST_POS - 1'b1);
      send_fraction(MOST_POS, 1);
      send_fraction(1, MOST_POS);
      // consecutive Fibonacci numbers: longest remainder chain
      send_fraction(1836311903, 1134903170);
      drain_results();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 73; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 73; end
            default: begin send_idle_pct = 30; rsp_stall_pct = 30; end
         endcase
         for (int i = 0; i < PHASE_ITEMS; i++)
            send_random_fraction();
         // sender holds off until the block is empty
         drain_results();
      end

      send_idle_pct = 0;
      rsp_stall_pct = 0;
      for (int i = 0; i < 20; i++)
         send_random_fraction();
      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (fractions.errors == 0 && fractions.outstanding() == 0)
         $display("fraction_reducer test passed");
      else
         $display("fraction_reducer test failed");
      $finish;
   end

endmodule

`default_nettype wire
